@@ sv/pirp_pkg.sv @@
// types, codes and limits shared by the invite record parser
package pirp_pkg;

    // field tags, also used as parser phases
    localparam logic [3:0] TAG_VERSION = 4'd0;
    localparam logic [3:0] TAG_NODE    = 4'd1;
    localparam logic [3:0] TAG_KEY     = 4'd2;
    localparam logic [3:0] TAG_COUNT   = 4'd3;
    localparam logic [3:0] TAG_TYPE    = 4'd4;
    localparam logic [3:0] TAG_ALEN    = 4'd5;
    localparam logic [3:0] TAG_ADDR    = 4'd6;
    localparam logic [3:0] TAG_PORT    = 4'd7;
    localparam logic [3:0] TAG_PRIO    = 4'd8;
    localparam logic [3:0] TAG_EXPIRY  = 4'd9;
    localparam logic [3:0] TAG_NONCE   = 4'd10;
    localparam logic [3:0] TAG_SIG     = 4'd11;
    localparam logic [3:0] TAG_IGNORED = 4'd12;

    // status codes
    localparam logic [2:0] ST_PROGRESS  = 3'd0;
    localparam logic [2:0] ST_ACCEPTED  = 3'd1;
    localparam logic [2:0] ST_BAD_VER   = 3'd2;
    localparam logic [2:0] ST_TOO_MANY  = 3'd3;
    localparam logic [2:0] ST_ADDR_LONG = 3'd4;
    localparam logic [2:0] ST_TRUNC     = 3'd5;

    // record format
    localparam logic [7:0] VERSION_ONE       = 8'd1;
    localparam logic [7:0] MAX_ENDPOINTS     = 8'd16;
    localparam logic [7:0] MAX_ADDRESS_BYTES = 8'd64;
    localparam logic [6:0] LEN_NODE   = 7'd16;
    localparam logic [6:0] LEN_KEY    = 7'd32;
    localparam logic [6:0] LEN_PORT   = 7'd2;
    localparam logic [6:0] LEN_EXPIRY = 7'd8;
    localparam logic [6:0] LEN_NONCE  = 7'd16;
    localparam logic [6:0] LEN_SIG    = 7'd64;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_t;

    typedef struct packed {
        logic [3:0] field_tag;
        logic [5:0] field_offset;
        logic [3:0] endpoint_index;
        logic [7:0] data_byte;
        logic [2:0] status;
        logic       record_end;
    } out_t;

    typedef struct packed {
        logic [3:0] phase;
        logic [5:0] offset_count;
        logic [4:0] endpoint_total;
        logic [4:0] endpoint_seen;
        logic [6:0] address_length;
        logic [2:0] error_code;
        logic       complete_flag;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:          TAG_VERSION,
        offset_count:   6'd0,
        endpoint_total: 5'd0,
        endpoint_seen:  5'd0,
        address_length: 7'd0,
        error_code:     ST_PROGRESS,
        complete_flag:  1'b0
    };

endpackage

@@ sv/pirp_step.sv @@
// parser step: next state and tagged result for one byte
module pirp_step (
    input  pirp_pkg::state_t st,
    input  pirp_pkg::in_t    din,
    output pirp_pkg::state_t st_next,
    output pirp_pkg::out_t   res
);

    logic       active;
    logic       multi;
    logic [6:0] mlen;
    logic [3:0] mnext;
    logic [6:0] off_inc;
    logic [4:0] seen_inc;
    pirp_pkg::state_t nx;

    assign off_inc  = {1'b0, st.offset_count} + 7'd1;
    assign seen_inc = st.endpoint_seen + 5'd1;
    assign active   = (st.error_code == pirp_pkg::ST_PROGRESS) && !st.complete_flag;

    // phase decode and field bookkeeping
    always_comb begin
        nx    = st;
        multi = 1'b0;
        mlen  = 7'd0;
        mnext = pirp_pkg::TAG_IGNORED;
        if (active) begin
            unique case (st.phase)
                pirp_pkg::TAG_VERSION: begin
                    if (din.in_byte != pirp_pkg::VERSION_ONE) begin
                        nx.error_code = pirp_pkg::ST_BAD_VER;
                    end else begin
                        nx.phase = pirp_pkg::TAG_NODE;
                    end
                end
                pirp_pkg::TAG_NODE: begin
                    multi = 1'b1;
                    mlen  = pirp_pkg::LEN_NODE;
                    mnext = pirp_pkg::TAG_KEY;
                end
                pirp_pkg::TAG_KEY: begin
                    multi = 1'b1;
                    mlen  = pirp_pkg::LEN_KEY;
                    mnext = pirp_pkg::TAG_COUNT;
                end
                pirp_pkg::TAG_COUNT: begin
                    if (din.in_byte > pirp_pkg::MAX_ENDPOINTS) begin
                        nx.error_code = pirp_pkg::ST_TOO_MANY;
                    end else begin
                        nx.endpoint_total = din.in_byte[4:0];
                        nx.endpoint_seen  = 5'd0;
                        nx.phase = (din.in_byte != 8'd0) ? pirp_pkg::TAG_TYPE
                                                         : pirp_pkg::TAG_EXPIRY;
                    end
                end
                pirp_pkg::TAG_TYPE: begin
                    nx.phase = pirp_pkg::TAG_ALEN;
                end
                pirp_pkg::TAG_ALEN: begin
                    if (din.in_byte > pirp_pkg::MAX_ADDRESS_BYTES) begin
                        nx.error_code = pirp_pkg::ST_ADDR_LONG;
                    end else begin
                        nx.address_length = din.in_byte[6:0];
                        nx.offset_count   = 6'd0;
                        nx.phase = (din.in_byte != 8'd0) ? pirp_pkg::TAG_ADDR
                                                         : pirp_pkg::TAG_PORT;
                    end
                end
                pirp_pkg::TAG_ADDR: begin
                    multi = 1'b1;
                    mlen  = st.address_length;
                    mnext = pirp_pkg::TAG_PORT;
                end
                pirp_pkg::TAG_PORT: begin
                    multi = 1'b1;
                    mlen  = pirp_pkg::LEN_PORT;
                    mnext = pirp_pkg::TAG_PRIO;
                end
                pirp_pkg::TAG_PRIO: begin
                    nx.endpoint_seen = seen_inc;
                    nx.phase = (seen_inc >= st.endpoint_total) ? pirp_pkg::TAG_EXPIRY
                                                               : pirp_pkg::TAG_TYPE;
                end
                pirp_pkg::TAG_EXPIRY: begin
                    multi = 1'b1;
                    mlen  = pirp_pkg::LEN_EXPIRY;
                    mnext = pirp_pkg::TAG_NONCE;
                end
                pirp_pkg::TAG_NONCE: begin
                    multi = 1'b1;
                    mlen  = pirp_pkg::LEN_NONCE;
                    mnext = pirp_pkg::TAG_SIG;
                end
                pirp_pkg::TAG_SIG: begin
                    multi = 1'b1;
                    mlen  = pirp_pkg::LEN_SIG;
                    mnext = pirp_pkg::TAG_IGNORED;
                end
                default: begin
                    nx.error_code = pirp_pkg::ST_TRUNC;
                end
            endcase

            // multi-byte field: count through, then move on
            if (multi) begin
                if (off_inc >= mlen) begin
                    nx.offset_count = 6'd0;
                    if (mnext == pirp_pkg::TAG_IGNORED) begin
                        nx.complete_flag = 1'b1;
                    end else begin
                        nx.phase = mnext;
                    end
                end else begin
                    nx.offset_count = off_inc[5:0];
                end
            end
        end
    end

    // result fields
    always_comb begin
        res.field_tag      = pirp_pkg::TAG_IGNORED;
        res.field_offset   = 6'd0;
        res.endpoint_index = 4'd0;
        res.data_byte      = din.in_byte;
        res.record_end     = din.in_last;
        if (active) begin
            res.field_tag    = st.phase;
            res.field_offset = st.offset_count;
            if (st.phase >= pirp_pkg::TAG_TYPE && st.phase <= pirp_pkg::TAG_PRIO) begin
                res.endpoint_index = st.endpoint_seen[3:0];
            end
        end
        if (nx.error_code != pirp_pkg::ST_PROGRESS) begin
            res.status = nx.error_code;
        end else if (nx.complete_flag) begin
            res.status = pirp_pkg::ST_ACCEPTED;
        end else begin
            res.status = din.in_last ? pirp_pkg::ST_TRUNC : pirp_pkg::ST_PROGRESS;
        end
    end

    // restart after the last byte of a record
    assign st_next = din.in_last ? pirp_pkg::STATE_RESET : nx;

endmodule

@@ sv/peer_invite_record_parser_core.sv @@
// top level of the invite record parser: input register, parser state, result register
//
//   channel | ports                       | moves
//   --------+-----------------------------+------------------------------
//   input   | s_valid, s_ready, s_data    | one record byte + last flag
//   result  | m_valid, m_ready, m_data    | one tagged byte + status
//
// one transfer in and one out per cycle when neither side stalls
// a byte passes from the input register into the result register, which drives the result port
// parser state advances as a byte moves from the input register to the result register
// aresetn (synchronous, low) empties both registers and returns the parser to the version field
// a stall at the result side holds both registers; the input register still fills if empty
module peer_invite_record_parser_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  pirp_pkg::in_t    s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output pirp_pkg::out_t   m_data
);

    logic             in_valid_reg;
    pirp_pkg::in_t    in_data_reg;
    pirp_pkg::state_t state_reg;
    pirp_pkg::state_t state_next;
    pirp_pkg::out_t   res_next;
    pirp_pkg::out_t   out_data_reg;
    logic             out_valid_reg;
    logic             out_free;
    logic             advance;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    pirp_step u_step (
        .st      (state_reg),
        .din     (in_data_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    // control and parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= pirp_pkg::STATE_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= res_next;
        end
    end

endmodule

@@ sv/pirp_checker.sv @@
// port-level checks for the invite record parser, bound to the top level
module pirp_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input pirp_pkg::out_t m_data
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // the last byte always carries a final status
    a_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.record_end |-> m_data.status != pirp_pkg::ST_PROGRESS)
        else $error("record end with status in progress");

    // truncated is reported only on the last byte
    a_trunc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.record_end |-> m_data.status != pirp_pkg::ST_TRUNC)
        else $error("truncated before record end");

    // ignored bytes only follow an error or a complete record
    a_ignored: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.field_tag == pirp_pkg::TAG_IGNORED
        |-> m_data.status != pirp_pkg::ST_PROGRESS)
        else $error("ignored byte while record in progress");

    // endpoint index only on endpoint fields
    a_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.field_tag < pirp_pkg::TAG_TYPE
                    || m_data.field_tag > pirp_pkg::TAG_PRIO)
        |-> m_data.endpoint_index == 4'd0)
        else $error("endpoint index outside endpoint fields");

endmodule

bind peer_invite_record_parser_core pirp_checker u_pirp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
